@@ rtl/ppgm_pkg.sv @@
// Package for the plain PGM text parser: word types, status codes, character
// constants and the push bundle between the parser and the result queue.
// No dependencies.
package ppgm_pkg;

	localparam int MAX_DIM = 4096;
	localparam logic [16:0] ACC_CAP = 17'h10000;
	localparam logic [16:0] MAX_LEVEL_LIMIT = 17'h0FFFF;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_P     = 8'h50;

	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_MAGIC      = 3'd1;
	localparam logic [2:0] ERR_CHAR       = 3'd2;
	localparam logic [2:0] ERR_SIZES      = 3'd3;
	localparam logic [2:0] ERR_MAX_LINE   = 3'd4;
	localparam logic [2:0] ERR_OVER_MAX   = 3'd5;
	localparam logic [2:0] ERR_HEADER     = 3'd6;
	localparam logic [2:0] ERR_TOO_LARGE  = 3'd7;

	typedef enum logic [1:0] {
		PH_MAGIC,
		PH_SIZE,
		PH_MAX,
		PH_PIX
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [11:0] column;
		logic [11:0] row;
		logic [7:0]  pixel_value;
		logic [2:0]  status_code;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [15:0] max_level;
		logic        last_of_run;
	} out_item_t;

	// Up to two result words are written into the queue per accepted word.
	typedef struct packed {
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} push_t;

endpackage

@@ rtl/ppgm_if.sv @@
// Valid/ready channel interfaces for the text input and the result output.
// Depends on ppgm_pkg.
interface ppgm_text_if import ppgm_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ppgm_result_if import ppgm_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ppgm_parser.sv @@
// Parser core: holds the header and position state and turns one accepted
// word into up to two result words. Depends on ppgm_pkg.
module ppgm_parser import ppgm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t word,
	output push_t    push
);

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  magic_pos;
		logic        at_line_start;
		logic        in_comment;
		logic        line_has_char;
		logic        in_number;
		logic [16:0] acc;
		logic [1:0]  size_count;
		logic [12:0] width;
		logic [12:0] height;
		logic [15:0] max_v;
		logic [11:0] next_col;
		logic [12:0] next_row;
		logic [2:0]  err;
	} pst_t;

	typedef struct packed {
		pst_t        s;
		logic        emit;
		logic [11:0] col;
		logic [11:0] row;
		logic [7:0]  val;
	} fin_t;

	localparam pst_t ST_RESET = '{
		phase: PH_MAGIC, magic_pos: 2'd0, at_line_start: 1'b1, in_comment: 1'b0,
		line_has_char: 1'b0, in_number: 1'b0, acc: 17'd0, size_count: 2'd0,
		width: 13'd0, height: 13'd0, max_v: 16'd0, next_col: 12'd0,
		next_row: 13'd0, err: ERR_NONE
	};

	pst_t        st_q;
	pst_t        st_next;
	fin_t        fin;
	logic        skip;
	logic        is_digit;
	logic [3:0]  digit;
	logic [20:0] acc_prod;
	out_item_t   pix_item;
	out_item_t   stat_item;

	function automatic logic rows_done(input pst_t s);
		return (s.width == 13'd0) || (s.next_row >= s.height);
	endfunction

	function automatic fin_t fin_none(input pst_t s);
		fin_t f;
		f.s    = s;
		f.emit = 1'b0;
		f.col  = '0;
		f.row  = '0;
		f.val  = '0;
		return f;
	endfunction

	function automatic fin_t finish_number(input pst_t s);
		fin_t        f;
		logic [12:0] col_inc;
		f = fin_none(s);
		f.s.in_number = 1'b0;
		col_inc = {1'b0, s.next_col} + 13'd1;
		unique case (s.phase)
			PH_MAGIC: ;
			PH_SIZE: begin
				if (s.acc > 17'(MAX_DIM))
					f.s.err = ERR_TOO_LARGE;
				else if (s.size_count == 2'd1)
					f.s.width = s.acc[12:0];
				else
					f.s.height = s.acc[12:0];
			end
			PH_MAX: begin
				if (s.acc > MAX_LEVEL_LIMIT)
					f.s.err = ERR_TOO_LARGE;
				else
					f.s.max_v = s.acc[15:0];
			end
			PH_PIX: begin
				if (!rows_done(s)) begin
					if (s.acc > {1'b0, s.max_v}) begin
						f.s.err = ERR_OVER_MAX;
					end else begin
						f.emit = 1'b1;
						f.col  = s.next_col;
						f.row  = s.next_row[11:0];
						f.val  = s.acc[7:0];
						if (col_inc >= s.width) begin
							f.s.next_col = 12'd0;
							f.s.next_row = s.next_row + 13'd1;
						end else begin
							f.s.next_col = col_inc[11:0];
						end
					end
				end
			end
		endcase
		return f;
	endfunction

	function automatic fin_t end_line(input pst_t s);
		fin_t f;
		if (s.in_number)
			f = finish_number(s);
		else
			f = fin_none(s);
		if (f.s.err == ERR_NONE && !f.s.in_comment) begin
			if (f.s.phase == PH_SIZE) begin
				f.s.phase = PH_MAX;
			end else if (f.s.phase == PH_MAX) begin
				if (!f.s.line_has_char)
					f.s.err = ERR_MAX_LINE;
				else
					f.s.phase = PH_PIX;
			end
		end
		f.s.at_line_start = 1'b1;
		f.s.in_comment    = 1'b0;
		f.s.line_has_char = 1'b0;
		f.s.in_number     = 1'b0;
		return f;
	endfunction

	assign is_digit = (word.data_byte >= CH_ZERO) && (word.data_byte <= CH_NINE);
	assign digit    = 4'(word.data_byte - CH_ZERO);

	always_comb begin
		fin      = fin_none(st_q);
		skip     = 1'b0;
		acc_prod = '0;
		st_next  = st_q;
		if (word.end_of_file) begin
			if (st_q.err == ERR_NONE) begin
				if (st_q.phase == PH_MAGIC) begin
					if (st_q.magic_pos == 2'd2)
						fin.s.phase = PH_SIZE;
					else
						fin.s.err = ERR_MAGIC;
				end else if (st_q.line_has_char || st_q.in_number) begin
					fin = end_line(st_q);
				end
				if (fin.s.err == ERR_NONE && fin.s.phase != PH_PIX)
					fin.s.err = ERR_HEADER;
			end
			st_next = ST_RESET;
		end else if (st_q.err == ERR_NONE) begin
			if (st_q.phase == PH_MAGIC) begin
				if (word.data_byte == CH_LF) begin
					if (st_q.magic_pos == 2'd2)
						fin.s.phase = PH_SIZE;
					else
						fin.s.err = ERR_MAGIC;
				end else if (st_q.magic_pos == 2'd0 && word.data_byte == CH_P) begin
					fin.s.magic_pos = 2'd1;
				end else if (st_q.magic_pos == 2'd1 && word.data_byte == CH_TWO) begin
					fin.s.magic_pos = 2'd2;
				end else begin
					fin.s.err = ERR_MAGIC;
				end
			end else if (word.data_byte == CH_LF) begin
				fin = end_line(st_q);
			end else begin
				if (fin.s.at_line_start) begin
					fin.s.at_line_start = 1'b0;
					if (word.data_byte == CH_HASH) begin
						fin.s.in_comment = 1'b1;
						skip = 1'b1;
					end else if (fin.s.phase == PH_PIX && rows_done(fin.s)) begin
						// Lines after the last row, or with no image at all, are skipped.
						fin.s.in_comment = 1'b1;
					end
				end
				fin.s.line_has_char = 1'b1;
				if (!skip && !fin.s.in_comment) begin
					if (is_digit) begin
						if (!fin.s.in_number) begin
							if (fin.s.phase == PH_SIZE) begin
								if (fin.s.size_count >= 2'd2) begin
									fin.s.err = ERR_SIZES;
									skip = 1'b1;
								end else begin
									fin.s.size_count = fin.s.size_count + 2'd1;
								end
							end
							if (!skip) begin
								fin.s.in_number = 1'b1;
								fin.s.acc = 17'd0;
							end
						end
						if (!skip) begin
							acc_prod = {4'd0, fin.s.acc} * 21'd10 + {17'd0, digit};
							if (acc_prod > {4'd0, ACC_CAP})
								fin.s.acc = ACC_CAP;
							else
								fin.s.acc = acc_prod[16:0];
						end
					end else begin
						if (fin.s.in_number)
							fin = finish_number(fin.s);
						if (fin.s.err == ERR_NONE) begin
							if (fin.s.phase == PH_MAX)
								fin.s.err = ERR_MAX_LINE;
							else if (word.data_byte != CH_SPACE)
								fin.s.err = ERR_CHAR;
						end
					end
				end
			end
			st_next = fin.s;
		end
	end

	always_comb begin
		pix_item              = '0;
		pix_item.kind         = KIND_PIXEL;
		pix_item.column       = fin.col;
		pix_item.row          = fin.row;
		pix_item.pixel_value  = fin.val;
		pix_item.last_of_run  = !word.end_of_file;

		stat_item              = '0;
		stat_item.kind         = KIND_STATUS;
		stat_item.status_code  = fin.s.err;
		stat_item.image_width  = fin.s.width;
		stat_item.image_height = fin.s.height;
		stat_item.max_level    = fin.s.max_v;
		stat_item.last_of_run  = 1'b1;

		push.count  = 2'({1'b0, fin.emit} + {1'b0, word.end_of_file});
		push.first  = fin.emit ? pix_item : stat_item;
		push.second = stat_item;
		if (!accept)
			push.count = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_RESET;
		else if (accept)
			st_q <= st_next;
	end

endmodule

@@ rtl/ppgm_res_fifo.sv @@
// Four-word result queue: takes up to two words per cycle from the parser, hands
// one word per cycle to a ready result channel. Depends on ppgm_pkg, ppgm_if.
module ppgm_res_fifo import ppgm_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  push_t          push,
	output logic           room,
	ppgm_result_if.source  result
);

	out_item_t  mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;

	assign pop          = result.valid && result.ready;
	assign result.valid = (count_q != 3'd0);
	assign result.data  = mem_q[rd_ptr_q];
	// Two free places are needed, since an end word may bring two results.
	assign room         = (count_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[wr_ptr_q] <= push.first;
		if (push.count == 2'd2)
			mem_q[wr_ptr_q + 2'd1] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.count;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + {1'b0, push.count} - {2'd0, pop};
		end
	end

endmodule

@@ rtl/plain_pgm_text_parser.sv @@
// Plain PGM (P2) text parser, top level: one text word per cycle in while the
// result queue has room, pixel and status words out. The parser state advances
// by one word for each word taken and the results are queued; a text word is
// taken in the cycle it is offered as long as the result queue has two free
// places, so with the result side draining the block sustains one byte per
// clock, and each result is registered in the queue when its word is taken.
// An end word can give a final pixel and the status word; these leave the
// queue one after the other, one word per cycle being the limit of the result
// channel. Depends on ppgm_pkg, ppgm_if, ppgm_parser and ppgm_res_fifo.
module plain_pgm_text_parser import ppgm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	ppgm_text_if.sink     text,
	ppgm_result_if.source result
);

	push_t push;
	logic  room;
	logic  accept;

	assign text.ready = room;
	assign accept     = text.valid && room;

	ppgm_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.word   (text.data),
		.push   (push)
	);

	ppgm_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.result (result)
	);

endmodule

@@ rtl/ppgm_checker.sv @@
// Port-level checks for the plain PGM text parser, bound to the top level.
// Depends on ppgm_pkg.
module ppgm_checker import ppgm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      text_valid,
	input logic      text_ready,
	input in_item_t  text_data,
	input logic      res_valid,
	input logic      res_ready,
	input out_item_t res_data
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.kind == KIND_STATUS |-> res_data.last_of_run)
		else $error("status word not marked last");

	a_pixel_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.kind == KIND_PIXEL |->
			res_data.status_code == ERR_NONE && res_data.image_width == 13'd0 &&
			res_data.image_height == 13'd0 && res_data.max_level == 16'd0)
		else $error("pixel word carries status fields");

	a_eof_result: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_ready && text_data.end_of_file |=> res_valid)
		else $error("no result after end word");

	a_status_follows: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res_data.kind == KIND_PIXEL && !res_data.last_of_run
		|=> res_valid && res_data.kind == KIND_STATUS)
		else $error("status word missing after final pixel");

endmodule

bind plain_pgm_text_parser ppgm_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.text_valid (text.valid),
	.text_ready (text.ready),
	.text_data  (text.data),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_data   (result.data)
);

@@ bench/tb.sv @@
// Self-checking bench for plain_pgm_text_parser: directed short files, then
// random PGM text checked word by word against a behavioural predictor.
// Depends on ppgm_pkg, ppgm_if and the parser RTL.
module tb;
	import ppgm_pkg::*;

	localparam int N_DIR        = 23;
	localparam int RANDOM_WORDS = 2000;
	localparam int CALM_AFTER   = 1800;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 3000;
	localparam int TAIL_CYCLES  = 20;

	typedef struct packed {
		logic [7:0] ch;
		logic       eof;
		logic       typed;
		logic [2:0] code;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ppgm_text_if   text_ch ();
	ppgm_result_if result_ch ();

	plain_pgm_text_parser uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch)
	);

	always #5 clk = ~clk;

	// Short files whose final status can be read straight off the format rules.
	dir_row_t dir_rows [N_DIR] = '{
		'{8'hFF, 1'b1, 1'b1, ERR_MAGIC},
		'{CH_P, 1'b0, 1'b0, ERR_NONE},
		'{CH_TWO, 1'b0, 1'b0, ERR_NONE},
		'{8'h00, 1'b1, 1'b1, ERR_HEADER},
		'{CH_P, 1'b0, 1'b0, ERR_NONE},
		'{8'h00, 1'b0, 1'b0, ERR_NONE},
		'{8'h5A, 1'b1, 1'b1, ERR_MAGIC},
		'{CH_P, 1'b0, 1'b0, ERR_NONE},
		'{CH_TWO, 1'b0, 1'b0, ERR_NONE},
		'{CH_LF, 1'b0, 1'b0, ERR_NONE},
		'{8'hFF, 1'b0, 1'b0, ERR_NONE},
		'{8'h00, 1'b1, 1'b1, ERR_CHAR},
		'{CH_P, 1'b0, 1'b0, ERR_NONE},
		'{CH_TWO, 1'b0, 1'b0, ERR_NONE},
		'{CH_LF, 1'b0, 1'b0, ERR_NONE},
		'{8'h31, 1'b0, 1'b0, ERR_NONE},
		'{CH_SPACE, 1'b0, 1'b0, ERR_NONE},
		'{8'h31, 1'b0, 1'b0, ERR_NONE},
		'{CH_LF, 1'b0, 1'b0, ERR_NONE},
		'{CH_NINE, 1'b0, 1'b0, ERR_NONE},
		'{CH_LF, 1'b0, 1'b0, ERR_NONE},
		'{8'h37, 1'b0, 1'b0, ERR_NONE},
		'{8'h00, 1'b1, 1'b1, ERR_NONE}
	};

	// Parser state as the predictor sees it.
	phase_t     cur_phase;
	logic [1:0] magic_pos;
	bit         at_start;
	bit         skip_line;
	bit         line_used;
	bit         in_num;
	int         acc;
	int         size_cnt;
	int         img_w;
	int         img_h;
	int         max_lv;
	int         col_next;
	int         row_next;
	logic [2:0] err;

	out_item_t  expected_words [$];
	logic [7:0] file_text [$];

	int mismatch_count = 0;
	int results_seen = 0;
	int words_sent = 0;
	int quiet_cycles = 0;
	int idle_rate = 0;
	int stall_rate = 0;
	bit calm = 1'b0;
	bit held_off = 1'b0;

	function automatic void parser_reset();
		cur_phase = PH_MAGIC;
		magic_pos = 2'd0;
		at_start = 1'b1;
		skip_line = 1'b0;
		line_used = 1'b0;
		in_num = 1'b0;
		acc = 0;
		size_cnt = 0;
		img_w = 0;
		img_h = 0;
		max_lv = 0;
		col_next = 0;
		row_next = 0;
		err = ERR_NONE;
	endfunction

	function automatic void push_result(logic kind, int col, int row, int val,
			logic [2:0] st, int w, int h, int m);
		out_item_t r;
		r.kind = kind;
		r.column = col[11:0];
		r.row = row[11:0];
		r.pixel_value = val[7:0];
		r.status_code = st;
		r.image_width = w[12:0];
		r.image_height = h[12:0];
		r.max_level = m[15:0];
		r.last_of_run = 1'b0;
		expected_words.push_back(r);
	endfunction

	function automatic bit rows_complete();
		return img_w == 0 || row_next >= img_h;
	endfunction

	function automatic void close_number();
		int a;
		a = acc;
		in_num = 1'b0;
		case (cur_phase)
			PH_SIZE: begin
				if (a > MAX_DIM) err = ERR_TOO_LARGE;
				else if (size_cnt == 1) img_w = a;
				else img_h = a;
			end
			PH_MAX: begin
				if (a > 65535) err = ERR_TOO_LARGE;
				else max_lv = a;
			end
			PH_PIX: begin
				if (!rows_complete()) begin
					if (a > max_lv) begin
						err = ERR_OVER_MAX;
					end else begin
						push_result(KIND_PIXEL, col_next, row_next, a, ERR_NONE, 0, 0, 0);
						col_next++;
						if (col_next >= img_w) begin
							col_next = 0;
							row_next++;
						end
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void close_line();
		if (in_num) close_number();
		if (err == ERR_NONE && !skip_line) begin
			if (cur_phase == PH_SIZE) begin
				cur_phase = PH_MAX;
			end else if (cur_phase == PH_MAX) begin
				if (!line_used) err = ERR_MAX_LINE;
				else cur_phase = PH_PIX;
			end
		end
		at_start = 1'b1;
		skip_line = 1'b0;
		line_used = 1'b0;
		in_num = 1'b0;
	endfunction

	function automatic void take_char(logic [7:0] b);
		if (cur_phase == PH_MAGIC) begin
			if (b == CH_LF) begin
				if (magic_pos == 2'd2) cur_phase = PH_SIZE;
				else err = ERR_MAGIC;
			end else if (magic_pos == 2'd0 && b == CH_P) begin
				magic_pos = 2'd1;
			end else if (magic_pos == 2'd1 && b == CH_TWO) begin
				magic_pos = 2'd2;
			end else begin
				err = ERR_MAGIC;
			end
			return;
		end
		if (b == CH_LF) begin
			close_line();
			return;
		end
		if (at_start) begin
			at_start = 1'b0;
			line_used = 1'b1;
			if (b == CH_HASH) begin
				skip_line = 1'b1;
				return;
			end
			// Lines that start once the image is complete are passed over.
			if (cur_phase == PH_PIX && rows_complete()) skip_line = 1'b1;
		end
		line_used = 1'b1;
		if (skip_line) return;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			if (!in_num) begin
				if (cur_phase == PH_SIZE) begin
					if (size_cnt >= 2) begin
						err = ERR_SIZES;
						return;
					end
					size_cnt++;
				end
				in_num = 1'b1;
				acc = 0;
			end
			acc = acc * 10 + (int'(b) - int'(CH_ZERO));
			if (acc > int'(ACC_CAP)) acc = int'(ACC_CAP);
			return;
		end
		// A number ended by any other character is taken before that character is judged.
		if (in_num) close_number();
		if (err != ERR_NONE) return;
		if (cur_phase == PH_MAX) err = ERR_MAX_LINE;
		else if (b != CH_SPACE) err = ERR_CHAR;
	endfunction

	function automatic void predict_word(in_item_t w);
		int first;
		first = expected_words.size();
		if (w.end_of_file) begin
			if (err == ERR_NONE) begin
				if (cur_phase == PH_MAGIC) begin
					if (magic_pos == 2'd2) cur_phase = PH_SIZE;
					else err = ERR_MAGIC;
				end else if (line_used || in_num) begin
					close_line();
				end
				if (err == ERR_NONE && cur_phase != PH_PIX) err = ERR_HEADER;
			end
			push_result(KIND_STATUS, 0, 0, 0, err, img_w, img_h, max_lv);
			parser_reset();
		end else if (err == ERR_NONE) begin
			take_char(w.data_byte);
		end
		if (expected_words.size() > first) expected_words[$].last_of_run = 1'b1;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 30)
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (expected_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 30)
					$display("%0t: result word expected none actual kind %0d value %0d",
						$time, result_ch.data.kind, result_ch.data.pixel_value);
			end else begin
				want = expected_words.pop_front();
				check_field("kind", want.kind, result_ch.data.kind);
				check_field("column", want.column, result_ch.data.column);
				check_field("row", want.row, result_ch.data.row);
				check_field("pixel_value", want.pixel_value, result_ch.data.pixel_value);
				check_field("status_code", want.status_code, result_ch.data.status_code);
				check_field("image_width", want.image_width, result_ch.data.image_width);
				check_field("image_height", want.image_height, result_ch.data.image_height);
				check_field("max_level", want.max_level, result_ch.data.max_level);
				check_field("last_of_run", want.last_of_run, result_ch.data.last_of_run);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
					$display("== FAIL ==");
					$finish;
				end
			end
		end
	end

	// Result side: random stalls, and once a long hold-off so that the queue fills.
	initial begin
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0) stall_rate = $urandom_range(0, 3);
			if (!held_off && results_seen >= 100) begin
				held_off = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && stall_rate != 0 && $urandom_range(1, 8) <= stall_rate) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	task automatic offer_word(in_item_t w, logic typed, logic [2:0] code);
		if (!calm && idle_rate != 0 && $urandom_range(1, 8) <= idle_rate) begin
			text_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.data <= w;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		predict_word(w);
		if (typed) expected_words[$].status_code = code;
		words_sent++;
		if (words_sent >= CALM_AFTER) calm = 1'b1;
	endtask

	task automatic add_str(string s);
		for (int i = 0; i < s.len(); i++) file_text.push_back(s[i]);
	endtask

	task automatic add_num(int n);
		add_str($sformatf("%0d", n));
	endtask

	task automatic add_comments();
		logic [7:0] b;
		repeat ($urandom_range(0, 2)) begin
			if ($urandom_range(0, 3) == 0) begin
				file_text.push_back(CH_HASH);
				repeat ($urandom_range(0, 6)) begin
					b = 8'($urandom_range(0, 255));
					if (b == CH_LF) b = CH_HASH;
					file_text.push_back(b);
				end
				file_text.push_back(CH_LF);
			end
		end
	endtask

	function automatic int pick_dim();
		case ($urandom_range(0, 29))
			0: return 0;
			1: return MAX_DIM;
			2: return MAX_DIM + 1;
			3: return $urandom_range(5000, 2000000);
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	function automatic int pick_max();
		case ($urandom_range(0, 29))
			0: return 0;
			1: return 65535;
			2: return 65536;
			3: return $urandom_range(70000, 999999);
			4: return 255;
			default: return $urandom_range(1, 300);
		endcase
	endfunction

	// Mostly well-formed files with random content; a few are broken or pure noise.
	task automatic build_file();
		int w;
		int h;
		int m;
		int n_pix;
		int v;
		int sel;
		file_text.delete();
		sel = $urandom_range(0, 99);
		if (sel < 6) begin
			if (sel < 3) add_str("P2\n");
			repeat ($urandom_range(1, 30)) file_text.push_back(8'($urandom_range(0, 255)));
			return;
		end
		case ($urandom_range(0, 24))
			0: add_str("P5\n");
			1: add_str("p2\n");
			2: add_str("P2 \n");
			3: begin
				add_str("P");
				return;
			end
			4: begin
				add_str("P2");
				return;
			end
			5: add_str("P2\r\n");
			default: add_str("P2\n");
		endcase
		add_comments();

		w = pick_dim();
		h = pick_dim();
		case ($urandom_range(0, 39))
			0: add_str("\n");
			1: begin
				add_num(w);
				add_str("\n");
			end
			2: begin
				add_num(w);
				add_str(" ");
				add_num(h);
				add_str(" 3\n");
			end
			3: begin
				add_num(w);
				add_str("x");
				add_num(h);
				add_str("\n");
			end
			4: begin
				add_num(w);
				add_str(" ");
				add_num(h);
				add_str("\r\n");
			end
			5: return;
			default: begin
				repeat ($urandom_range(0, 2)) add_str(" ");
				add_num(w);
				repeat ($urandom_range(1, 3)) add_str(" ");
				add_num(h);
				repeat ($urandom_range(0, 2)) add_str(" ");
				add_str("\n");
			end
		endcase
		add_comments();

		m = pick_max();
		case ($urandom_range(0, 39))
			0: add_str("\n");
			1: begin
				add_num(m);
				add_str("a\n");
			end
			2: begin
				add_str(" ");
				add_num(m);
				add_str("\n");
			end
			3: return;
			4: begin
				add_num(m);
				return;
			end
			default: begin
				add_num(m);
				add_str("\n");
			end
		endcase

		if (w > 0 && w <= 8 && h <= 8) n_pix = w * h;
		else n_pix = $urandom_range(0, 12);
		if ($urandom_range(0, 3) == 0) n_pix += $urandom_range(1, 3);
		if ($urandom_range(0, 7) == 0) n_pix = $urandom_range(0, n_pix);
		for (int k = 0; k < n_pix; k++) begin
			case ($urandom_range(0, 49))
				0: v = m + 1;
				1: v = $urandom_range(0, 99999);
				default: v = $urandom_range(0, m);
			endcase
			add_num(v);
			if (k == n_pix - 1 && $urandom_range(0, 2) == 0) break;
			if (w > 0 && (k + 1) % w == 0 && $urandom_range(0, 9) < 7) begin
				add_str("\n");
			end else begin
				case ($urandom_range(0, 29))
					0: add_str("#");
					1: add_str("\n# note\n");
					2: add_str("\t");
					3, 4, 5, 6: add_str("\n");
					7: add_str("  ");
					default: add_str(" ");
				endcase
			end
		end
		if ($urandom_range(0, 5) == 0) add_str("9 z\n");
		if ($urandom_range(0, 3) == 0) add_str("\n");
	endtask

	initial begin
		text_ch.valid <= 1'b0;
		text_ch.data <= '0;
		parser_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			offer_word(in_item_t'({dir_rows[i].ch, dir_rows[i].eof}),
				dir_rows[i].typed, dir_rows[i].code);

		while (words_sent < N_DIR + RANDOM_WORDS) begin
			build_file();
			idle_rate = $urandom_range(0, 3);
			foreach (file_text[i])
				offer_word(in_item_t'({file_text[i], 1'b0}), 1'b0, ERR_NONE);
			offer_word(in_item_t'({8'($urandom_range(0, 255)), 1'b1}), 1'b0, ERR_NONE);
		end
		text_ch.valid <= 1'b0;

		while (expected_words.size() != 0) @(posedge clk);
		// The queue may still hold a word in flight; give it time to show up.
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_words.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
